FILE: hdl/dsa_pkg.sv
// shared types and constants of the descriptor slot allocator
// no dependencies; imported by every module of the block
package dsa_pkg;

  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int STRIDE_W    = 16;
  localparam int HANDLE_W    = 64;
  localparam int STATUS_W    = 2;
  localparam int WORD_W      = 32;
  localparam int BIT_W       = 5;
  localparam int PROD_W      = IDX_W + STRIDE_W;
  localparam int INDEX_REACH = 1024;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 144;
  localparam int APB_DATA_W  = 64;
  localparam int APB_ADDR_W  = 5;
  localparam int REG_SEL_W   = 2;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  localparam logic [REG_SEL_W-1:0] REG_CPU_BASE   = 2'd0;
  localparam logic [REG_SEL_W-1:0] REG_GPU_BASE   = 2'd1;
  localparam logic [REG_SEL_W-1:0] REG_STRIDE     = 2'd2;
  localparam logic [REG_SEL_W-1:0] REG_SLOT_COUNT = 2'd3;

  typedef struct packed {
    logic [HANDLE_W-1:0] cpu_base;
    logic [HANDLE_W-1:0] gpu_base;
    logic [STRIDE_W-1:0] stride;
    logic [CNT_W-1:0]    eff_count;
    logic                heap_clear;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic look;
    logic merge;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic clearing;
  } sts_t;

endpackage

FILE: hdl/descriptor_slot_allocator.sv
// descriptor slot allocator: lowest free slot allocation with cpu and gpu handles
// top level; depends on dsa_pkg, dsa_regs, dsa_ctrl and dsa_dp
//
// Requests arrive as beats on the s_axis channel: tuser selects allocate (0) or
// release (1), tdata carries the slot to release. Each request gives exactly one
// result beat on m_axis: tuser holds the status, tdata the slot offset and the
// two handles (base plus offset times stride).
// A request runs through these steps in order: the beat is taken, the row summary
// picks a row and the single-port row memory is read, the row is updated and offset
// times stride is multiplied, then the handle adds load the result register. The next
// request is taken once the sequencer is back in idle after the final step.
// The result register frees the sequencer: a new request is taken while a result
// waits, but its final step holds until the receiver takes the waiting beat.
// After reset every slot below the slot count is free, with no clearing pass.
// Writing slot_count through the apb port frees every slot; requests wait
// while the registered clear strobe rebuilds the row summary.
module descriptor_slot_allocator
  import dsa_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // slot_index[9:0], zero pad
  input  logic [0:0]             s_axis_tuser,  // op[0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // slot_offset[9:0], cpu_handle[73:10],
                                                // gpu_handle[137:74], zero pad
  output logic [STATUS_W-1:0]    m_axis_tuser   // status[1:0]
);

  cfg_t                cfg;
  cmd_t                cmd;
  sts_t                sts;
  logic [IDX_W-1:0]    slot_offset;
  logic [HANDLE_W-1:0] cpu_handle;
  logic [HANDLE_W-1:0] gpu_handle;

  dsa_regs #(
    .SLOTS(SLOTS)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dsa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  dsa_dp #(
    .SLOTS(SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (s_axis_tuser[0]),
    .slot_index_i  (s_axis_tdata[IDX_W-1:0]),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status_o      (m_axis_tuser),
    .slot_offset_o (slot_offset),
    .cpu_handle_o  (cpu_handle),
    .gpu_handle_o  (gpu_handle)
  );

  assign m_axis_tdata = OUT_TDATA_W'({gpu_handle, cpu_handle, slot_offset});

endmodule

FILE: hdl/dsa_regs.sv
// configuration register file behind the apb port
// depends on dsa_pkg; feeds handle bases, stride and slot count to the datapath
module dsa_regs
  import dsa_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  localparam int DEPTH = (SLOTS < INDEX_REACH) ? SLOTS : INDEX_REACH;

  logic [HANDLE_W-1:0]  cpu_base_q, cpu_base_d;
  logic [HANDLE_W-1:0]  gpu_base_q, gpu_base_d;
  logic [STRIDE_W-1:0]  stride_q, stride_d;
  logic [CNT_W-1:0]     slot_count_q, slot_count_d;
  logic                 heap_clear_q, heap_clear_d;
  logic                 wr_en;
  logic [REG_SEL_W-1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[APB_ADDR_W-1 -: REG_SEL_W];

  always_comb begin
    cpu_base_d   = cpu_base_q;
    gpu_base_d   = gpu_base_q;
    stride_d     = stride_q;
    slot_count_d = slot_count_q;
    heap_clear_d = 1'b0;
    if (wr_en) begin
      unique case (reg_sel)
        REG_CPU_BASE:   cpu_base_d = pwdata;
        REG_GPU_BASE:   gpu_base_d = pwdata;
        REG_STRIDE:     stride_d   = pwdata[STRIDE_W-1:0];
        REG_SLOT_COUNT: begin
          slot_count_d = pwdata[CNT_W-1:0];
          heap_clear_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_base_q   <= '0;
      gpu_base_q   <= '0;
      stride_q     <= STRIDE_W'(32);
      slot_count_q <= CNT_W'(1024);
      heap_clear_q <= 1'b0;
    end else begin
      cpu_base_q   <= cpu_base_d;
      gpu_base_q   <= gpu_base_d;
      stride_q     <= stride_d;
      slot_count_q <= slot_count_d;
      heap_clear_q <= heap_clear_d;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CPU_BASE:   prdata = cpu_base_q;
      REG_GPU_BASE:   prdata = gpu_base_q;
      REG_STRIDE:     prdata = APB_DATA_W'(stride_q);
      REG_SLOT_COUNT: prdata = APB_DATA_W'(slot_count_q);
    endcase
  end

  assign cfg_o.cpu_base   = cpu_base_q;
  assign cfg_o.gpu_base   = gpu_base_q;
  assign cfg_o.stride     = stride_q;
  assign cfg_o.eff_count  = (slot_count_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : slot_count_q;
  assign cfg_o.heap_clear = heap_clear_q;

endmodule

FILE: hdl/dsa_ctrl.sv
// request sequencer: accept, row lookup, merge, result load
// depends on dsa_pkg; drives the datapath by command struct
module dsa_ctrl
  import dsa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOK   = 2'd1;
  localparam logic [1:0] S_MERGE  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  assign s_axis_tready = (state_q == S_IDLE) & ~sts_i.clearing;

  assign cmd_o.accept = s_axis_tvalid & s_axis_tready;
  assign cmd_o.look   = (state_q == S_LOOK);
  assign cmd_o.merge  = (state_q == S_MERGE);
  assign cmd_o.finish = (state_q == S_FINISH) & sts_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (cmd_o.accept) state_d = S_LOOK;
      S_LOOK:   state_d = S_MERGE;
      S_MERGE:  state_d = S_FINISH;
      S_FINISH: if (sts_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/dsa_dp.sv
// datapath: free bitmap in row memory, row summary, encoders, handle math, result register
// depends on dsa_pkg; sequenced by dsa_ctrl, configured by dsa_regs
module dsa_dp
  import dsa_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic                   op_i,
  input  logic [IDX_W-1:0]       slot_index_i,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [STATUS_W-1:0]    status_o,
  output logic [IDX_W-1:0]       slot_offset_o,
  output logic [HANDLE_W-1:0]    cpu_handle_o,
  output logic [HANDLE_W-1:0]    gpu_handle_o
);

  localparam int DEPTH = (SLOTS < INDEX_REACH) ? SLOTS : INDEX_REACH;
  localparam int ROWS  = (DEPTH + WORD_W - 1) / WORD_W;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [WORD_W-1:0]   mem_q [ROWS];
  logic [WORD_W-1:0]   rd_q;
  logic [ROWS-1:0]     valid_q, valid_d;
  logic [ROWS-1:0]     summary_q, summary_d;
  logic                op_q;
  logic [IDX_W-1:0]    idx_q;
  logic [ROW_W-1:0]    row_q, row_d, enc_row;
  logic                ok_q, ok_d;
  logic                in_range;
  logic [WORD_W-1:0]   init_word, word_sel, new_word;
  logic [BIT_W-1:0]    enc_bit, bit_sel;
  logic [IDX_W-1:0]    offset_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [IDX_W-1:0]    offset_q;
  logic [PROD_W-1:0]   prod_q;
  logic                mem_we;
  logic                tvalid_q;

  // row lookup
  always_comb begin
    enc_row = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (summary_q[r]) enc_row = ROW_W'(r);
    end
  end

  assign in_range = (CNT_W'(idx_q) < cfg_i.eff_count);

  always_comb begin
    if (op_q == OP_ALLOC) begin
      row_d = enc_row;
      ok_d  = |summary_q;
    end else begin
      row_d = in_range ? idx_q[BIT_W +: ROW_W] : '0;
      ok_d  = in_range;
    end
  end

  // row merge
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      init_word[b] = (CNT_W'({row_q, BIT_W'(b)}) < cfg_i.eff_count);
    end
  end

  assign word_sel = valid_q[row_q] ? rd_q : init_word;

  always_comb begin
    enc_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (word_sel[b]) enc_bit = BIT_W'(b);
    end
  end

  always_comb begin
    bit_sel  = (op_q == OP_ALLOC) ? enc_bit : idx_q[BIT_W-1:0];
    new_word = word_sel;
    new_word[bit_sel] = (op_q == OP_RELEASE);
    mem_we   = cmd_i.merge & ok_q;
    if (op_q == OP_ALLOC) begin
      status_d = ok_q ? ST_ALLOCATED : ST_FULL;
      offset_d = ok_q ? IDX_W'({row_q, enc_bit}) : '0;
    end else begin
      status_d = ok_q ? ST_RELEASED : ST_RANGE;
      offset_d = '0;
    end
  end

  always_comb begin
    valid_d   = valid_q;
    summary_d = summary_q;
    if (cfg_i.heap_clear) begin
      valid_d = '0;
      for (int r = 0; r < ROWS; r++) begin
        summary_d[r] = (CNT_W'({ROW_W'(r), {BIT_W{1'b0}}}) < cfg_i.eff_count);
      end
    end else if (mem_we) begin
      valid_d[row_q]   = 1'b1;
      summary_d[row_q] = |new_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[row_q] <= new_word;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) rd_q <= mem_q[row_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= op_i;
      idx_q <= slot_index_i;
    end
    if (cmd_i.look) begin
      row_q <= row_d;
      ok_q  <= ok_d;
    end
    if (cmd_i.merge) begin
      status_q <= status_d;
      offset_q <= offset_d;
      prod_q   <= PROD_W'(offset_d) * PROD_W'(cfg_i.stride);
    end
    if (cmd_i.finish) begin
      status_o      <= status_q;
      slot_offset_o <= offset_q;
      if (status_q == ST_ALLOCATED) begin
        cpu_handle_o <= cfg_i.cpu_base + HANDLE_W'(prod_q);
        gpu_handle_o <= cfg_i.gpu_base + HANDLE_W'(prod_q);
      end else begin
        cpu_handle_o <= '0;
        gpu_handle_o <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      summary_q <= '1;
      tvalid_q  <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      summary_q <= summary_d;
      if (cmd_i.finish) begin
        tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        tvalid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid  = tvalid_q;
  assign sts_o.out_free = ~tvalid_q | m_axis_tready;
  assign sts_o.clearing = cfg_i.heap_clear;

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(tvalid_q) |-> $past(cmd_i.finish))
    else $error("result beat appeared without a finish step");

  a_summary_matches_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.merge && op_q == OP_ALLOC && ok_q) |-> (word_sel != '0))
    else $error("row summary flagged a free slot in a full row");

  a_clear_drops_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.heap_clear |=> (valid_q == '0))
    else $error("heap rebuild left stale rows");

endmodule

FILE: tb/descriptor_slot_allocator_tb.sv
// self-checking testbench of descriptor_slot_allocator: directed table, then random phases
// depends on dsa_pkg and the descriptor_slot_allocator rtl; results are checked beat by beat
// against a typed table result or an in-bench allocator predictor mirroring the apb writes
module descriptor_slot_allocator_tb;
  import dsa_pkg::*;

  localparam int SLOTS       = 1024;
  localparam int CLK_PERIOD  = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_N       = 35;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    offset;
    logic [HANDLE_W-1:0] cpu;
    logic [HANDLE_W-1:0] gpu;
  } result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [REG_SEL_W-1:0] reg_sel;
    logic [HANDLE_W-1:0]  value;
    logic                 op;
    logic [IDX_W-1:0]     idx;
    logic                 typed;
    result_t              res;
  } dir_row_t;

  localparam result_t RES_NONE     = '{ST_ALLOCATED, 10'd0, 64'd0, 64'd0};
  localparam result_t RES_FULL     = '{ST_FULL, 10'd0, 64'd0, 64'd0};
  localparam result_t RES_RELEASED = '{ST_RELEASED, 10'd0, 64'd0, 64'd0};
  localparam result_t RES_RANGE    = '{ST_RANGE, 10'd0, 64'd0, 64'd0};

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_ALLOC, 10'd0, 1'b1, RES_NONE},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_ALLOC, 10'd0, 1'b1,
      '{ST_ALLOCATED, 10'd1, 64'd32, 64'd32}},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_RELEASE, 10'd1, 1'b1, RES_RELEASED},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_RELEASE, 10'd1, 1'b1, RES_RELEASED},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_RELEASE, 10'd1023, 1'b1, RES_RELEASED},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_ALLOC, 10'd1023, 1'b0, RES_NONE},
    '{ROW_CFG, REG_CPU_BASE, 64'hFFFF_FFFF_FFFF_FFF0, OP_ALLOC, 10'd0, 1'b0, RES_NONE},
    '{ROW_CFG, REG_GPU_BASE, 64'h8000_0000_0000_0000, OP_ALLOC, 10'd0, 1'b0, RES_NONE},
    '{ROW_CFG, REG_STRIDE, 64'h0000_0000_0000_FFFF, OP_ALLOC, 10'd0, 1'b0, RES_NONE},
    '{ROW_CFG, REG_SLOT_COUNT, 64'd2, OP_ALLOC, 10'd0, 1'b0, RES_NONE},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_ALLOC, 10'd0, 1'b1,
      '{ST_ALLOCATED, 10'd0, 64'hFFFF_FFFF_FFFF_FFF0, 64'h8000_0000_0000_0000}},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_ALLOC, 10'd0, 1'b0, RES_NONE},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_ALLOC, 10'd0, 1'b1, RES_FULL},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_RELEASE, 10'd2, 1'b1, RES_RANGE},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_RELEASE, 10'd1023, 1'b1, RES_RANGE},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_RELEASE, 10'd0, 1'b1, RES_RELEASED},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_ALLOC, 10'd0, 1'b0, RES_NONE},
    '{ROW_CFG, REG_SLOT_COUNT, 64'd0, OP_ALLOC, 10'd0, 1'b0, RES_NONE},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_ALLOC, 10'd0, 1'b1, RES_FULL},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_RELEASE, 10'd0, 1'b1, RES_RANGE},
    '{ROW_CFG, REG_SLOT_COUNT, 64'hFFFF_FFFF_FFFF_FFFF, OP_ALLOC, 10'd0, 1'b0, RES_NONE},
    '{ROW_CFG, REG_STRIDE, 64'd0, OP_ALLOC, 10'd0, 1'b0, RES_NONE},
    '{ROW_CFG, REG_CPU_BASE, 64'h0123_4567_89AB_CDEF, OP_ALLOC, 10'd0, 1'b0, RES_NONE},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_ALLOC, 10'd0, 1'b0, RES_NONE},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_RELEASE, 10'd1023, 1'b1, RES_RELEASED},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_ALLOC, 10'd0, 1'b0, RES_NONE},
    '{ROW_CFG, REG_SLOT_COUNT, 64'd1, OP_ALLOC, 10'd0, 1'b0, RES_NONE},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_ALLOC, 10'd0, 1'b0, RES_NONE},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_ALLOC, 10'd0, 1'b1, RES_FULL},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_RELEASE, 10'd1, 1'b1, RES_RANGE},
    '{ROW_REQ, REG_CPU_BASE, 64'd0, OP_RELEASE, 10'd0, 1'b1, RES_RELEASED},
    '{ROW_CFG, REG_SLOT_COUNT, 64'd1024, OP_ALLOC, 10'd0, 1'b0, RES_NONE},
    '{ROW_CFG, REG_STRIDE, 64'd32, OP_ALLOC, 10'd0, 1'b0, RES_NONE},
    '{ROW_CFG, REG_CPU_BASE, 64'd0, OP_ALLOC, 10'd0, 1'b0, RES_NONE},
    '{ROW_CFG, REG_GPU_BASE, 64'd0, OP_ALLOC, 10'd0, 1'b0, RES_NONE}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [0:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  logic [HANDLE_W-1:0] cpu_base_q;
  logic [HANDLE_W-1:0] gpu_base_q;
  logic [STRIDE_W-1:0] stride_q;
  logic [CNT_W-1:0]    slot_cnt_q;
  logic                free_map [SLOTS];
  int                  used_slots [$];
  result_t             pending_results [$];

  int fail_cnt     = 0;
  int cycle_cnt    = 0;
  int src_idle_pct = 29;
  int dst_idle_pct = 29;

  descriptor_slot_allocator #(
    .SLOTS(SLOTS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int unsigned active_slots();
    int unsigned lim;
    lim = slot_cnt_q;
    if (lim > SLOTS) lim = SLOTS;
    if (lim > INDEX_REACH) lim = INDEX_REACH;
    return lim;
  endfunction

  function automatic result_t predict_request(input logic op, input logic [IDX_W-1:0] idx);
    result_t     r;
    int unsigned lim;
    int          slot;
    r = '0;
    lim = active_slots();
    if (op == OP_ALLOC) begin
      slot = 0;
      while (slot < lim && !free_map[slot]) slot++;
      if (slot < lim) begin
        free_map[slot] = 1'b0;
        used_slots.push_back(slot);
        r.status = ST_ALLOCATED;
        r.offset = slot[IDX_W-1:0];
        r.cpu    = cpu_base_q + 64'(r.offset) * 64'(stride_q);
        r.gpu    = gpu_base_q + 64'(r.offset) * 64'(stride_q);
      end else begin
        r.status = ST_FULL;
      end
    end else if (idx < lim) begin
      free_map[idx] = 1'b1;
      for (int k = 0; k < used_slots.size(); k++) begin
        if (used_slots[k] == int'(idx)) begin
          used_slots.delete(k);
          break;
        end
      end
      r.status = ST_RELEASED;
    end else begin
      r.status = ST_RANGE;
    end
    return r;
  endfunction

  task automatic apb_write(input logic [REG_SEL_W-1:0] sel, input logic [HANDLE_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (sel)
      REG_CPU_BASE: cpu_base_q = value;
      REG_GPU_BASE: gpu_base_q = value;
      REG_STRIDE:   stride_q   = value[STRIDE_W-1:0];
      REG_SLOT_COUNT: begin
        slot_cnt_q = value[CNT_W-1:0];
        foreach (free_map[i]) free_map[i] = 1'b1;
        used_slots.delete();
      end
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_request(input logic op, input logic [IDX_W-1:0] idx,
                              input logic typed, input result_t typed_res);
    result_t pred;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_TDATA_W-IDX_W){1'b0}}, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_request(op, idx);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t exp_res;
    result_t got_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res.status = m_axis_tuser;
      got_res.offset = m_axis_tdata[9:0];
      got_res.cpu    = m_axis_tdata[73:10];
      got_res.gpu    = m_axis_tdata[137:74];
      if (pending_results.size() == 0) begin
        $error("result beat with no request pending");
        fail_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (got_res.status !== exp_res.status) begin
          $error("status expected %0d actual %0d", exp_res.status, got_res.status);
          fail_cnt++;
        end
        if (got_res.offset !== exp_res.offset) begin
          $error("slot_offset expected %0d actual %0d", exp_res.offset, got_res.offset);
          fail_cnt++;
        end
        if (got_res.cpu !== exp_res.cpu) begin
          $error("cpu_handle expected %h actual %h", exp_res.cpu, got_res.cpu);
          fail_cnt++;
        end
        if (got_res.gpu !== exp_res.gpu) begin
          $error("gpu_handle expected %h actual %h", exp_res.gpu, got_res.gpu);
          fail_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [IDX_W-1:0]    idx;
    logic                op;
    logic [HANDLE_W-1:0] value;
    int                  n_items;
    int                  alloc_pct;
    int                  count;
    int unsigned         lim;
    int                  pick;

    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ALLOC;
    cpu_base_q    = '0;
    gpu_base_q    = '0;
    stride_q      = 16'd32;
    slot_cnt_q    = 11'd1024;
    foreach (free_map[i]) free_map[i] = 1'b1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DIR_N; r++) begin
      if (DIR_ROWS[r].kind == ROW_CFG) begin
        wait_idle();
        apb_write(DIR_ROWS[r].reg_sel, DIR_ROWS[r].value);
      end else begin
        send_request(DIR_ROWS[r].op, DIR_ROWS[r].idx, DIR_ROWS[r].typed, DIR_ROWS[r].res);
      end
    end

    for (int p = 0; p < 7; p++) begin
      n_items      = 80;
      alloc_pct    = $urandom_range(3, 7) * 10;
      src_idle_pct = 29;
      dst_idle_pct = 29;
      case (p)
        0: count = 1024;
        1: count = $urandom_range(1, 40);
        2: begin
          count        = 2047;
          n_items      = 150;
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
        3: begin
          count     = $urandom_range(513, 2047);
          n_items   = 560;
          alloc_pct = 95;
        end
        4: count = $urandom_range(0, 2047);
        5: count = 1;
        default: count = $urandom_range(2, 16);
      endcase

      wait_idle();
      case ($urandom_range(3))
        0: value = '0;
        1: value = '1;
        default: value = {$urandom, $urandom};
      endcase
      apb_write(REG_CPU_BASE, value);
      case ($urandom_range(3))
        0: value = '0;
        1: value = '1;
        default: value = {$urandom, $urandom};
      endcase
      apb_write(REG_GPU_BASE, value);
      value = {$urandom, $urandom};
      case ($urandom_range(3))
        0: value[STRIDE_W-1:0] = '0;
        1: value[STRIDE_W-1:0] = '1;
        default: ;
      endcase
      apb_write(REG_STRIDE, value);
      value = {$urandom, $urandom};
      value[CNT_W-1:0] = count[CNT_W-1:0];
      apb_write(REG_SLOT_COUNT, value);

      for (int n = 0; n < n_items; n++) begin
        lim = active_slots();
        idx = $urandom_range(1023);
        op  = ($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_RELEASE;
        if (op == OP_RELEASE) begin
          pick = $urandom_range(99);
          if (pick < 75 && used_slots.size() > 0) begin
            idx = 10'(used_slots[$urandom_range(used_slots.size() - 1)]);
          end else if (pick < 90 && lim > 0) begin
            idx = 10'($urandom_range(lim - 1));
          end
        end
        send_request(op, idx, 1'b0, RES_NONE);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
